[rtl/core/zbr_pkg.sv]
package zbr_pkg;

  // Buffer geometry
  localparam int BUF_WIDTH  = 320;
  localparam int BUF_HEIGHT = 200;
  localparam int NPIX       = BUF_WIDTH * BUF_HEIGHT;
  localparam int ADDR_W     = $clog2(NPIX);
  localparam int COL_W      = $clog2(BUF_WIDTH);
  localparam int ROW_W      = $clog2(BUF_HEIGHT);

  // Projection constants, Q0.16 scale and Q.12 distances
  localparam int SCALE_Q16 = 2949;
  localparam int DIST_Q12  = 22528;
  localparam int NEAR_Q12  = 410;

  // Screen divider widths
  localparam int NUM_W = 44;
  localparam int DEN_W = 29;
  localparam int CNT_W = $clog2(NUM_W);

  // Command queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input item kinds
  localparam logic [1:0] KIND_CLR  = 2'd0;
  localparam logic [1:0] KIND_PLOT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Register indexes
  localparam logic [3:0] REG_FMT = 4'd0;
  localparam logic [3:0] REG_CY  = 4'd1;
  localparam logic [3:0] REG_SY  = 4'd2;
  localparam logic [3:0] REG_CP  = 4'd3;
  localparam logic [3:0] REG_SP  = 4'd4;
  localparam logic [3:0] REG_LX  = 4'd5;
  localparam logic [3:0] REG_LY  = 4'd6;
  localparam logic [3:0] REG_LZ  = 4'd7;

  // Background color channels
  localparam logic [7:0] BG_R = 8'h0D;
  localparam logic [7:0] BG_G = 8'h0A;
  localparam logic [7:0] BG_B = 8'h12;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_PLOT,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       depth;
    logic [23:0]       color;
  } cmd_t;

  typedef struct packed {
    logic               fmt;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_pitch;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
  } cfg_t;

  function automatic logic [23:0] pack_color(input logic fmt, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    if (fmt) begin
      return {r, g, b};
    end
    return {b, g, r};
  endfunction

endpackage

[rtl/core/zbr_div.sv]
module zbr_div
  import zbr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, num_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quo  = num_r;

endmodule

[rtl/core/zbr_fifo.sv]
module zbr_fifo
  import zbr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // pointer and fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= FIFO_AW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= FIFO_AW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= (FIFO_AW+1)'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= (FIFO_AW+1)'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/core/zbr_front.sv]
module zbr_front
  import zbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               hold,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [8:0]         in_read_col,
  input  logic [7:0]         in_read_row,
  output logic               push,
  output cmd_t               push_cmd,
  input  logic               full
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_YAW_M = 4'd1;
  localparam logic [3:0] F_YAW_S = 4'd2;
  localparam logic [3:0] F_PIT_M = 4'd3;
  localparam logic [3:0] F_PIT_S = 4'd4;
  localparam logic [3:0] F_PRJ_M = 4'd5;
  localparam logic [3:0] F_PRJ_S = 4'd6;
  localparam logic [3:0] F_NUM   = 4'd7;
  localparam logic [3:0] F_DST   = 4'd8;
  localparam logic [3:0] F_DIV   = 4'd9;
  localparam logic [3:0] F_CHK   = 4'd10;
  localparam logic [3:0] F_PUSH  = 4'd11;

  logic [3:0] state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;

  // index 0 is the point, index 1 the normal
  logic signed [15:0] va_r [2];
  logic signed [15:0] vb_r [2];
  logic signed [15:0] vc_r [2];
  logic signed [31:0] m_r  [2][4];
  logic signed [18:0] xr_r [2];
  logic signed [18:0] zr_r [2];
  logic signed [34:0] q_r  [2][4];
  logic signed [21:0] ox_r [2];
  logic signed [21:0] oy_r [2];
  logic signed [21:0] oz_r [2];
  logic signed [35:0] sp_r [3];
  logic signed [37:0] dp_r [3];
  logic signed [23:0] px_r, py_r;
  logic signed [24:0] pz_r;
  logic [24:0]        dot_r;
  logic signed [NUM_W-1:0] numx_r, numy_r;
  logic [DEN_W-1:0]   den_r;
  logic [15:0]        depth_r;
  logic [23:0]        color_r;

  logic signed [32:0] yaw_x [2];
  logic signed [32:0] yaw_z [2];
  logic signed [35:0] pit_y [2];
  logic signed [35:0] pit_z [2];
  logic signed [24:0] pz_c;
  logic signed [39:0] dot_sum;
  logic [35:0]        r_t, g_t, b_t;
  logic [7:0]         r_c, g_c, b_c;
  logic [NUM_W-1:0]   absx, absy, qx, qy;
  logic               busx, busy_y, div_start;
  logic               okx, oky;
  logic [COL_W-1:0]   sx;
  logic [ROW_W-1:0]   sy;

  // rotation sums, floored by 2^14
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      yaw_x[v] = 33'(m_r[v][0]) + 33'(m_r[v][1]);
      yaw_z[v] = 33'(m_r[v][3]) - 33'(m_r[v][2]);
      pit_y[v] = 36'(q_r[v][0]) - 36'(q_r[v][1]);
      pit_z[v] = 36'(q_r[v][2]) + 36'(q_r[v][3]);
    end
  end

  // projection and shading terms
  assign pz_c    = 25'($signed(sp_r[2][35:12])) + 25'(DIST_Q12);
  assign dot_sum = 40'(dp_r[0]) + 40'(dp_r[1]) + 40'(dp_r[2]);
  assign r_t = 36'(2539520) + 36'(315) * 36'(dot_r);
  assign g_t = 36'(163840) + 36'(15) * 36'(dot_r);
  assign b_t = 36'(409600) + 36'(45) * 36'(dot_r);
  assign r_c = (r_t[35:15] > 21'd255) ? 8'hFF : r_t[22:15];
  assign g_c = (g_t[35:14] > 22'd255) ? 8'hFF : g_t[21:14];
  assign b_c = (b_t[35:14] > 22'd255) ? 8'hFF : b_t[21:14];

  // screen divide on magnitudes, sign handled at the check
  assign absx      = numx_r[NUM_W-1] ? NUM_W'(-numx_r) : NUM_W'(numx_r);
  assign absy      = numy_r[NUM_W-1] ? NUM_W'(-numy_r) : NUM_W'(numy_r);
  assign div_start = (state_r == F_DST);

  zbr_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (absx),
    .den   (den_r),
    .busy  (busx),
    .quo   (qx)
  );

  zbr_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (absy),
    .den   (den_r),
    .busy  (busy_y),
    .quo   (qy)
  );

  assign okx = numx_r[NUM_W-1] ? (qx == '0) : (qx < NUM_W'(BUF_WIDTH));
  assign oky = numy_r[NUM_W-1] ? (qy == '0) : (qy < NUM_W'(BUF_HEIGHT));
  assign sx  = numx_r[NUM_W-1] ? '0 : qx[COL_W-1:0];
  assign sy  = numy_r[NUM_W-1] ? '0 : qy[ROW_W-1:0];

  assign in_ready = (state_r == F_IDLE) && !hold;
  assign push     = (state_r == F_PUSH) && !full;
  assign push_cmd = cmd_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = '{op: CMD_NONE, addr: '0, depth: '0, color: '0};
          state_nxt = F_PUSH;
          case (in_kind)
            KIND_CLR: begin
              cmd_nxt.op = CMD_CLR;
            end
            KIND_READ: begin
              if (in_read_col < BUF_WIDTH && in_read_row < BUF_HEIGHT) begin
                cmd_nxt.op   = CMD_READ;
                cmd_nxt.addr = ADDR_W'(ADDR_W'(in_read_row) * ADDR_W'(BUF_WIDTH)
                                       + ADDR_W'(in_read_col));
              end
            end
            KIND_PLOT: begin
              state_nxt = F_YAW_M;
            end
            default: begin
              cmd_nxt.op = CMD_NONE;
            end
          endcase
        end
      end
      F_YAW_M: state_nxt = F_YAW_S;
      F_YAW_S: state_nxt = F_PIT_M;
      F_PIT_M: state_nxt = F_PIT_S;
      F_PIT_S: state_nxt = F_PRJ_M;
      F_PRJ_M: state_nxt = F_PRJ_S;
      F_PRJ_S: begin
        if (pz_c < 25'(NEAR_Q12)) begin
          state_nxt = F_PUSH;
        end else begin
          state_nxt = F_NUM;
        end
      end
      F_NUM: state_nxt = F_DST;
      F_DST: state_nxt = F_DIV;
      F_DIV: begin
        if (!busx && !busy_y) begin
          state_nxt = F_CHK;
        end
      end
      F_CHK: begin
        if (okx && oky) begin
          cmd_nxt.op    = CMD_PLOT;
          cmd_nxt.addr  = ADDR_W'(ADDR_W'(sy) * ADDR_W'(BUF_WIDTH) + ADDR_W'(sx));
          cmd_nxt.depth = depth_r;
          cmd_nxt.color = color_r;
        end
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE) begin
      va_r[0] <= in_pos_x;
      vb_r[0] <= in_pos_y;
      vc_r[0] <= in_pos_z;
      va_r[1] <= in_normal_x;
      vb_r[1] <= in_normal_y;
      vc_r[1] <= in_normal_z;
    end
    for (int v = 0; v < 2; v++) begin
      // yaw products
      m_r[v][0] <= 32'(va_r[v]) * 32'(cfg.cos_yaw);
      m_r[v][1] <= 32'(vc_r[v]) * 32'(cfg.sin_yaw);
      m_r[v][2] <= 32'(va_r[v]) * 32'(cfg.sin_yaw);
      m_r[v][3] <= 32'(vc_r[v]) * 32'(cfg.cos_yaw);
      xr_r[v]   <= yaw_x[v][32:14];
      zr_r[v]   <= yaw_z[v][32:14];
      // pitch products
      q_r[v][0] <= 35'(vb_r[v]) * 35'(cfg.cos_pitch);
      q_r[v][1] <= 35'(zr_r[v]) * 35'(cfg.sin_pitch);
      q_r[v][2] <= 35'(vb_r[v]) * 35'(cfg.sin_pitch);
      q_r[v][3] <= 35'(zr_r[v]) * 35'(cfg.cos_pitch);
      ox_r[v]   <= 22'(xr_r[v]);
      oy_r[v]   <= pit_y[v][35:14];
      oz_r[v]   <= pit_z[v][35:14];
    end
    // projection scale and Lambert dot products
    sp_r[0] <= 36'(ox_r[0]) * 36'(SCALE_Q16);
    sp_r[1] <= 36'(oy_r[0]) * 36'(SCALE_Q16);
    sp_r[2] <= 36'(oz_r[0]) * 36'(SCALE_Q16);
    dp_r[0] <= 38'(ox_r[1]) * 38'(cfg.light_x);
    dp_r[1] <= 38'(oy_r[1]) * 38'(cfg.light_y);
    dp_r[2] <= 38'(oz_r[1]) * 38'(cfg.light_z);
    px_r    <= sp_r[0][35:12];
    py_r    <= sp_r[1][35:12];
    pz_r    <= pz_c;
    dot_r   <= dot_sum[39] ? '0 : dot_sum[38:14];
    // screen numerators, depth and color
    numx_r  <= NUM_W'(pz_r) * NUM_W'(5 * BUF_WIDTH) + NUM_W'(px_r) * NUM_W'(8 * BUF_WIDTH);
    numy_r  <= NUM_W'(pz_r) * NUM_W'(5 * BUF_HEIGHT) - NUM_W'(py_r) * NUM_W'(8 * BUF_WIDTH);
    den_r   <= DEN_W'(DEN_W'(pz_r) * DEN_W'(10));
    depth_r <= (pz_r > 25'sd65535) ? 16'hFFFF : pz_r[15:0];
    color_r <= pack_color(cfg.fmt, r_c, g_c, b_c);
  end

endmodule

[rtl/core/zbr_back.sv]
module zbr_back
  import zbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fmt,
  input  logic        fifo_empty,
  input  cmd_t        fifo_cmd,
  output logic        fifo_pop,
  output logic        init_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_pixel_color,
  output logic        out_written
);

  localparam logic [2:0] B_INIT = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_CLR  = 3'd2;
  localparam logic [2:0] B_RD   = 3'd3;
  localparam logic [2:0] B_PL   = 3'd4;

  logic [15:0] depth_mem [NPIX];
  logic [23:0] color_mem [NPIX];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] cur_addr_r;
  logic [15:0]       cur_depth_r;
  logic [23:0]       cur_color_r;
  logic [15:0]       depth_q_r;
  logic [23:0]       color_q_r;
  logic              out_valid_r, out_valid_nxt;
  logic [23:0]       out_color_r, out_color_nxt;
  logic              out_written_r, out_written_nxt;

  logic              out_free, hit, sweep, sweep_fmt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdepth;
  logic [23:0]       mem_wcolor;

  assign out_free  = !out_valid_r || out_ready;
  assign fifo_pop  = (state_r == B_IDLE) && !fifo_empty && out_free;
  assign init_busy = (state_r == B_INIT);
  assign sweep     = (state_r == B_INIT) || (state_r == B_CLR);
  assign hit       = (cur_depth_r < depth_q_r);
  // reset sweep always paints the format 0 background
  assign sweep_fmt = (state_r == B_CLR) ? fmt : 1'b0;

  // store write port: clearing sweep or a passing plot
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = cur_addr_r;
    mem_wdepth = cur_depth_r;
    mem_wcolor = cur_color_r;
    if (sweep) begin
      mem_we     = 1'b1;
      mem_waddr  = cnt_r;
      mem_wdepth = 16'hFFFF;
      mem_wcolor = pack_color(sweep_fmt, BG_R, BG_G, BG_B);
    end else if (state_r == B_PL && hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= mem_wdepth;
      color_mem[mem_waddr] <= mem_wcolor;
    end
    if (fifo_pop) begin
      depth_q_r <= depth_mem[fifo_cmd.addr];
      color_q_r <= color_mem[fifo_cmd.addr];
    end
  end

  // command sequencer and result word
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_color_nxt   = out_color_r;
    out_written_nxt = out_written_r;
    case (state_r)
      B_INIT, B_CLR: begin
        cnt_nxt = ADDR_W'(cnt_r + 1'b1);
        if (cnt_r == ADDR_W'(NPIX - 1)) begin
          cnt_nxt   = '0;
          state_nxt = B_IDLE;
          if (state_r == B_CLR) begin
            out_valid_nxt   = 1'b1;
            out_color_nxt   = '0;
            out_written_nxt = 1'b0;
          end
        end
      end
      B_IDLE: begin
        if (fifo_pop) begin
          case (fifo_cmd.op)
            CMD_CLR:  state_nxt = B_CLR;
            CMD_READ: state_nxt = B_RD;
            CMD_PLOT: state_nxt = B_PL;
            default: begin
              out_valid_nxt   = 1'b1;
              out_color_nxt   = '0;
              out_written_nxt = 1'b0;
            end
          endcase
        end
      end
      B_RD: begin
        out_valid_nxt   = 1'b1;
        out_color_nxt   = color_q_r;
        out_written_nxt = 1'b0;
        state_nxt       = B_IDLE;
      end
      B_PL: begin
        out_valid_nxt   = 1'b1;
        out_color_nxt   = hit ? cur_color_r : '0;
        out_written_nxt = hit;
        state_nxt       = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_color_r   <= out_color_nxt;
    out_written_r <= out_written_nxt;
    if (fifo_pop) begin
      cur_addr_r  <= fifo_cmd.addr;
      cur_depth_r <= fifo_cmd.depth;
      cur_color_r <= fifo_cmd.color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_written     = out_written_r;

  // nothing leaves the queue while the reset sweep runs
  a_no_pop_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_INIT) |-> !fifo_pop)
    else $error("queue popped during reset sweep");

  // a stored plot always carries a shaded, nonzero color
  a_written_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_written_r) |-> (out_color_r != '0))
    else $error("written word with zero color");

  // a plot goes from its compare state straight back to idle with its result valid
  a_plot_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_PL) |=> (state_r == B_IDLE && out_valid_r))
    else $error("plot did not finish");

endmodule

[rtl/core/zbuffer_point_splat_renderer.sv]
// Z-buffered point splat renderer with Lambert shading.
// Input channel (in_valid/in_ready): one word per item; kind selects clear,
// plot or read. Result channel (out_valid/out_ready): one word per item, in
// item order. Configuration (cfg_we/cfg_index/cfg_wdata) takes one register
// per cycle; write it only while the block is idle.
// A plot passes the front sequencer's rotate, project, bit-serial screen
// divide and check states, then the store read/compare/write.
// A read answers after its store fetch, a clear after one sweep over all
// 64000 pixels of both stores, one pixel per cycle on their write port.
// A four-word command queue parts the front from the store side, so the
// front starts the next item while the back finishes earlier ones.
// After reset the stores are swept to far depth and background color with
// in_ready low; configuration writes are taken meanwhile.
// When the receiver stalls, the result word holds in the output register,
// the queue fills and in_ready then drops.
module zbuffer_point_splat_renderer
  import zbr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [8:0]         in_read_col,
  input  logic [7:0]         in_read_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        out_pixel_color,
  output logic               out_written
);

  cfg_t cfg_r, cfg_nxt;
  logic push, full, pop, empty, init_busy;
  cmd_t push_cmd, pop_cmd;

  // register file writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FMT: cfg_nxt.fmt       = cfg_wdata[0];
        REG_CY:  cfg_nxt.cos_yaw   = cfg_wdata;
        REG_SY:  cfg_nxt.sin_yaw   = cfg_wdata;
        REG_CP:  cfg_nxt.cos_pitch = cfg_wdata;
        REG_SP:  cfg_nxt.sin_pitch = cfg_wdata;
        REG_LX:  cfg_nxt.light_x   = cfg_wdata;
        REG_LY:  cfg_nxt.light_y   = cfg_wdata;
        REG_LZ:  cfg_nxt.light_z   = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{fmt: 1'b0, cos_yaw: 16'sd16384, sin_yaw: 16'sd0,
                 cos_pitch: 16'sd16384, sin_pitch: 16'sd0,
                 light_x: 16'sd0, light_y: 16'sd0, light_z: 16'sd16384};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  zbr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .hold        (init_busy),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_pos_x    (in_pos_x),
    .in_pos_y    (in_pos_y),
    .in_pos_z    (in_pos_z),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .in_read_col (in_read_col),
    .in_read_row (in_read_row),
    .push        (push),
    .push_cmd    (push_cmd),
    .full        (full)
  );

  zbr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (pop_cmd),
    .empty (empty)
  );

  zbr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fmt             (cfg_r.fmt),
    .fifo_empty      (empty),
    .fifo_cmd        (pop_cmd),
    .fifo_pop        (pop),
    .init_busy       (init_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_written     (out_written)
  );

endmodule
